@@ rtl/sgm_pkg.sv @@
// Shared types and constants for the Sobel gradient magnitude core.
package sgm_pkg;

    localparam int unsigned CfgW   = 11;
    localparam int unsigned CoordW = 10;
    localparam int unsigned PixW   = 24;

    localparam logic [0:0] RegWidth  = 1'b0;
    localparam logic [0:0] RegHeight = 1'b1;

    // Datapath commands from the controller
    typedef struct packed {
        logic load;     // take input pixel, read line buffers
        logic shift;    // advance window, write line buffers
        logic calc;     // capture gradients of one result, start its root
        logic step;     // one root iteration
        logic emit;     // move one result into the output register
        logic [1:0] sel;// which of up to four results
        logic last;     // final result of this pixel
        logic restart;  // reset position
    } t_cmd;

    // Status from the datapath
    typedef struct packed {
        logic out_busy;
        logic root_last;    // current root step is the final one
        logic [1:0] nres;   // number of results minus one
        logic has_res;
    } t_stat;

endpackage

@@ rtl/sobel_gradient_magnitude_core.sv @@
// Top level of the Sobel gradient magnitude core.
//  channel  | dir | contents
//  s_axis   | in  | tdata: pixel_c0, pixel_c1, pixel_c2
//  m_axis   | out | tdata: out_row..mag_c2, tlast: last_result
//  cfg      | in  | index 0 width, 1 height
// A pixel goes through load and line-buffer read, evaluate, then per result
// (up to 4) capture, eight root steps and emit, then shift; the next pixel is
// taken only after shift. The single output register stalls the emit steps.
// Reset is synchronous; line buffers are not cleared.
module sobel_gradient_magnitude_core #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // pixel_c0, pixel_c1, pixel_c2
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // out_row, out_col, grad_x_c0..2, grad_y_c0..2, mag_c0..2
    output logic         m_axis_tlast,   // last_result
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_idx,
    input  logic [10:0]  i_cfg_data
);
    sgm_pkg::t_cmd  cmd;
    sgm_pkg::t_stat stat;

    sgm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_cfg_we(i_cfg_we), .i_stat(stat), .o_in_ready(s_axis_tready), .o_cmd(cmd)
    );

    sgm_dpath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .i_pix(s_axis_tdata),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_out_data(m_axis_tdata), .o_out_last(m_axis_tlast), .o_stat(stat)
    );
endmodule

@@ rtl/sgm_ctrl.sv @@
// Controller: sequences load, root, emit and shift steps per input pixel.
module sgm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_cfg_we,
    input  sgm_pkg::t_stat  i_stat,
    output logic            o_in_ready,
    output sgm_pkg::t_cmd   o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_CALC = 6'b000100,
        S_ROOT = 6'b001000,
        S_EMIT = 6'b010000,
        S_SHFT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_idx, n_idx;

    // Next state
    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_cmd.restart = i_cfg_we;
        o_cmd.sel = r_idx;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_idx = 2'd0;
                n_state = i_stat.has_res ? S_CALC : S_SHFT;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.step = 1'b1;
                if (i_stat.root_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = (r_idx == i_stat.nres);
                    n_idx = r_idx + 2'd1;
                    n_state = (r_idx == i_stat.nres) ? S_SHFT : S_CALC;
                end
            end
            S_SHFT: begin
                o_cmd.shift = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
        end
    end
endmodule

@@ rtl/sgm_dpath.sv @@
// Datapath: line buffers, window, gradients, root and output register.
module sgm_dpath #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sgm_pkg::t_cmd                 i_cmd,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [sgm_pkg::CfgW-1:0]      i_cfg_data,
    input  logic [sgm_pkg::PixW-1:0]      i_pix,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [103:0]                  o_out_data,
    output logic                          o_out_last,
    output sgm_pkg::t_stat                o_stat
);
    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned PW = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1;

    logic [sgm_pkg::CfgW-1:0] r_wreg, r_hreg;
    logic [PW-1:0] w_eff, h_eff;
    logic [PW-1:0] r_row, r_col;
    logic [sgm_pkg::PixW-1:0] mem_two [MAX_WIDTH];
    logic [sgm_pkg::PixW-1:0] mem_one [MAX_WIDTH];
    logic [sgm_pkg::PixW-1:0] r_top, r_mid, r_cur;
    logic [sgm_pkg::PixW-1:0] r_win [6];
    logic r_ov;
    logic [103:0] r_od;
    logic r_ol;

    // Clamp sizes
    always_comb begin
        w_eff = (r_wreg < 11'd3) ? PW'(3) :
                ((PW+11)'(r_wreg) > (PW+11)'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : PW'(r_wreg);
        h_eff = (r_hreg < 11'd3) ? PW'(3) :
                ((PW+11)'(r_hreg) > (PW+11)'(MAX_HEIGHT)) ? PW'(MAX_HEIGHT) : PW'(r_hreg);
    end

    logic last_col, last_row, inner_c;
    assign last_col = (r_col + PW'(1) == w_eff);
    assign last_row = (r_row + PW'(1) == h_eff);
    assign inner_c = (r_col >= PW'(2));

    logic [2:0] r_rb;

    // Result count
    logic up_on;
    logic [2:0] cnt;
    always_comb begin
        up_on = (r_row != '0) && (r_col != '0);
        cnt = 3'd0;
        if (up_on) cnt = last_col ? 3'd2 : 3'd1;
        if (last_row && r_col != '0) cnt = cnt + (last_col ? 3'd2 : 3'd1);
        o_stat.has_res = (cnt != 3'd0);
        o_stat.nres = 2'(cnt - 3'd1);
        o_stat.out_busy = r_ov && !i_out_ready;
        o_stat.root_last = (r_rb == 3'd0);
    end

    // Select result
    logic lower, bcol;
    logic [PW-1:0] pr, pc, ph;
    always_comb begin
        lower = up_on ? (last_col ? i_cmd.sel[1] : i_cmd.sel[0]) : 1'b1;
        bcol = last_col && (up_on ? i_cmd.sel[0] : i_cmd.sel[0]);
        if (up_on && !last_col) bcol = 1'b0;
        if (!up_on) bcol = last_col && i_cmd.sel[0];
        pr = lower ? r_row : r_row - PW'(1);
        pc = bcol ? w_eff - PW'(1) : r_col - PW'(1);
        ph = pr + PW'(2);
    end

    logic irow, icol;
    assign irow = (pr != '0) && (ph <= h_eff);
    assign icol = inner_c && !bcol;

    logic [8:0] sx [3];
    logic [8:0] sy [3];
    logic [16:0] sq [3];
    always_comb begin
        logic signed [9:0] hx0, hx1, hx2, hy0, hy1, hy2, ax, ay;
        logic signed [11:0] s;
        logic signed [17:0] q;
        logic [sgm_pkg::PixW-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2;
        a0 = r_win[1]; a1 = r_win[0]; a2 = r_top;
        b0 = r_win[3]; b1 = r_win[2]; b2 = r_mid;
        c0 = r_win[5]; c1 = r_win[4]; c2 = r_cur;
        for (int ch = 0; ch < 3; ch++) begin
            s = '0;
            hx0 = 10'(a2[ch*8+:8]) - 10'(a0[ch*8+:8]);
            hx1 = 10'(b2[ch*8+:8]) - 10'(b0[ch*8+:8]);
            hx2 = 10'(c2[ch*8+:8]) - 10'(c0[ch*8+:8]);
            hy0 = 10'((11'(a0[ch*8+:8]) + {2'b0, a1[ch*8+:8], 1'b0} + 11'(a2[ch*8+:8])) >> 2);
            hy1 = 10'((11'(b0[ch*8+:8]) + {2'b0, b1[ch*8+:8], 1'b0} + 11'(b2[ch*8+:8])) >> 2);
            hy2 = 10'((11'(c0[ch*8+:8]) + {2'b0, c1[ch*8+:8], 1'b0} + 11'(c2[ch*8+:8])) >> 2);
            if (!icol) begin
                hx0 = '0; hx1 = '0; hx2 = '0; hy0 = '0; hy1 = '0; hy2 = '0;
            end
            if (lower) begin
                ax = hx2; ay = hy2;
            end else if (irow) begin
                s = 12'(hx0) + 12'(hx1 <<< 1) + 12'(hx2);
                if (s < 0) s = s + 12'sd3;
                ax = 10'(s >>> 2);
                ay = hy0 - hy2;
            end else begin
                ax = hx1; ay = hy1;
            end
            sx[ch] = ax[8:0];
            sy[ch] = ay[8:0];
            q = ax * ax + ay * ay;
            sq[ch] = q[16:0];
        end
    end

    // Captured result and root, one bit per step from the top
    logic [sgm_pkg::CoordW-1:0] r_pr, r_pc;
    logic [8:0] r_sx [3];
    logic [8:0] r_sy [3];
    logic [16:0] r_sq [3];
    logic [7:0] r_rt [3];
    logic [7:0] rt_try [3];
    logic [15:0] rt_sq [3];
    logic [7:0] rt_next [3];
    logic [7:0] mg [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            rt_try[ch] = r_rt[ch] | (8'd1 << r_rb);
            rt_sq[ch] = 16'(rt_try[ch]) * 16'(rt_try[ch]);
            rt_next[ch] = ({1'b0, rt_sq[ch]} <= r_sq[ch]) ? rt_try[ch] : r_rt[ch];
            mg[ch] = r_sq[ch][16] ? 8'hFF : r_rt[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_pr <= pr[sgm_pkg::CoordW-1:0];
            r_pc <= pc[sgm_pkg::CoordW-1:0];
            for (int ch = 0; ch < 3; ch++) begin
                r_sx[ch] <= sx[ch];
                r_sy[ch] <= sy[ch];
                r_sq[ch] <= sq[ch];
                r_rt[ch] <= '0;
            end
            r_rb <= 3'd7;
        end else if (i_cmd.step) begin
            for (int ch = 0; ch < 3; ch++) r_rt[ch] <= rt_next[ch];
            r_rb <= r_rb - 3'd1;
        end
    end

    // Config and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wreg <= 11'd640;
            r_hreg <= 11'd480;
            r_row <= '0;
            r_col <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == sgm_pkg::RegWidth) r_wreg <= i_cfg_data;
                else r_hreg <= i_cfg_data;
            end
            if (i_cmd.restart) begin
                r_row <= '0;
                r_col <= '0;
            end else if (i_cmd.shift) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + PW'(1);
                end else begin
                    r_col <= r_col + PW'(1);
                end
            end
        end
    end

    // Line buffers and window
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur <= i_pix;
            r_top <= mem_two[r_col[AW-1:0]];
            r_mid <= mem_one[r_col[AW-1:0]];
        end
        if (i_cmd.shift) begin
            mem_two[r_col[AW-1:0]] <= r_mid;
            mem_one[r_col[AW-1:0]] <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_win[k] <= '0;
        end else if (i_cmd.shift) begin
            r_win[1] <= r_win[0]; r_win[0] <= r_top;
            r_win[3] <= r_win[2]; r_win[2] <= r_mid;
            r_win[5] <= r_win[4]; r_win[4] <= r_cur;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_od <= {6'b0, mg[2], mg[1], mg[0], r_sy[2], r_sy[1], r_sy[0],
                     r_sx[2], r_sx[1], r_sx[0], r_pc, r_pr};
            r_ol <= i_cmd.last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data = r_od;
    assign o_out_last = r_ol;
endmodule

@@ bench/sobel_gradient_magnitude_core_tb.sv @@
// Self-checking bench for the Sobel gradient magnitude core: random and directed frames.
module sobel_gradient_magnitude_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxW = 1024;

    typedef struct packed {
        logic        last;
        logic [7:0]  mag2, mag1, mag0;
        logic [8:0]  gy2, gy1, gy0;
        logic [8:0]  gx2, gx1, gx0;
        logic [9:0]  col;
        logic [9:0]  row;
    } t_grad;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    logic [0:0]   i_cfg_idx = '0;
    logic [10:0]  i_cfg_data = '0;

    sobel_gradient_magnitude_core u_top (.*);

    initial forever #1 i_clk = ~i_clk;

    // Predictor state
    logic [23:0] line_two[MaxW];
    logic [23:0] line_one[MaxW];
    logic [23:0] win[6];
    int unsigned cur_row, cur_col, cfg_w, cfg_h;

    t_grad grad_q[$];
    int    mismatches = 0;
    bit    timed_out = 0;
    bit    send_gaps = 1, recv_gaps = 1;
    int    hold_cycles = 0;
    int    idle_cycles = 0;

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v < 3) return 3;
        if (v > MaxW) return MaxW;
        return v;
    endfunction

    function automatic int chv(logic [23:0] p, int ch);
        return int'(p[8*ch +: 8]);
    endfunction

    function automatic int hpass_x(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                                   bit inner, int ch);
        if (!inner) return 0;
        return chv(c, ch) - chv(a, ch);
    endfunction

    function automatic int hpass_y(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                                   bit inner, int ch);
        if (!inner) return 0;
        return (chv(a, ch) + 2 * chv(b, ch) + chv(c, ch)) / 4;
    endfunction

    function automatic logic [7:0] isqrt(int v);
        int r;
        r = 0;
        if (v >= 65536) return 8'hFF;
        for (int b = 128; b != 0; b >>= 1)
            if ((r | b) * (r | b) <= v) r = r | b;
        return r[7:0];
    endfunction

    // Build one gradient result; rows u/m/d index the 3x3 window
    function automatic t_grad make_grad(int pr, int pc, logic [23:0] w3[3][3],
                                        int u, int m, int d, bit inner_c, int h);
        t_grad g;
        int sx[3], sy[3];
        bit inner_r;
        inner_r = (pr >= 1) && (pr + 2 <= h);
        for (int ch = 0; ch < 3; ch++) begin
            if (inner_r) begin
                sx[ch] = (hpass_x(w3[u][0], w3[u][1], w3[u][2], inner_c, ch)
                        + 2 * hpass_x(w3[m][0], w3[m][1], w3[m][2], inner_c, ch)
                        + hpass_x(w3[d][0], w3[d][1], w3[d][2], inner_c, ch)) / 4;
                sy[ch] = hpass_y(w3[u][0], w3[u][1], w3[u][2], inner_c, ch)
                       - hpass_y(w3[d][0], w3[d][1], w3[d][2], inner_c, ch);
            end else begin
                sx[ch] = hpass_x(w3[m][0], w3[m][1], w3[m][2], inner_c, ch);
                sy[ch] = hpass_y(w3[m][0], w3[m][1], w3[m][2], inner_c, ch);
            end
        end
        g.row = pr[9:0];
        g.col = pc[9:0];
        g.gx0 = sx[0][8:0]; g.gx1 = sx[1][8:0]; g.gx2 = sx[2][8:0];
        g.gy0 = sy[0][8:0]; g.gy1 = sy[1][8:0]; g.gy2 = sy[2][8:0];
        g.mag0 = isqrt(sx[0] * sx[0] + sy[0] * sy[0]);
        g.mag1 = isqrt(sx[1] * sx[1] + sy[1] * sy[1]);
        g.mag2 = isqrt(sx[2] * sx[2] + sy[2] * sy[2]);
        g.last = 1'b0;
        return g;
    endfunction

    // Advance the predictor by one pixel and queue its results
    task automatic predict_pixel(logic [23:0] pix);
        int unsigned w, h, r, c;
        logic [23:0] w3[3][3];
        t_grad res[$];
        bit last_c, inner;
        w = clamp_dim(cfg_w);
        h = clamp_dim(cfg_h);
        r = cur_row;
        c = cur_col;
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;
        for (int q = 0; q < 3; q++) begin
            w3[q][0] = win[q*2+1];
            w3[q][1] = win[q*2];
        end
        w3[0][2] = line_two[c];
        w3[1][2] = line_one[c];
        w3[2][2] = pix;
        last_c = (c + 1 == w);
        inner = (c >= 2) && (c <= w - 1);
        if (r >= 1 && c >= 1) begin
            res.push_back(make_grad(r - 1, c - 1, w3, 0, 1, 2, inner, h));
            if (last_c) res.push_back(make_grad(r - 1, w - 1, w3, 0, 1, 2, 0, h));
        end
        if (r + 1 == h && c >= 1) begin
            res.push_back(make_grad(r, c - 1, w3, 2, 2, 2, inner, h));
            if (last_c) res.push_back(make_grad(r, w - 1, w3, 2, 2, 2, 0, h));
        end
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[k]) grad_q.push_back(res[k]);
        line_two[c] = line_one[c];
        line_one[c] = pix;
        for (int q = 0; q < 3; q++) begin
            win[q*2+1] = win[q*2];
            win[q*2] = w3[q][2];
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        cur_row = r;
        cur_col = c;
    endtask

    // Send one pixel; hold valid until accepted, drop it only for a gap
    task automatic send_pixel(logic [23:0] pix);
        int gap;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixel(pix);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (grad_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write a register while idle; a write restarts the frame
    task automatic write_reg(logic [0:0] idx, int unsigned val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[10:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == sgm_pkg::RegWidth) cfg_w = val & 11'h7FF;
        else cfg_h = val & 11'h7FF;
        cur_row = 0;
        cur_col = 0;
    endtask

    function automatic logic [23:0] rand_pix();
        return 24'($urandom());
    endfunction

    // Full frames so that every line-buffer entry is written before use
    task automatic send_frames(int n);
        int total;
        total = n * clamp_dim(cfg_w) * clamp_dim(cfg_h);
        repeat (total) send_pixel(rand_pix());
    endtask

    task automatic test_extremes();
        logic [23:0] pat[9] = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF, 24'h000000,
                                24'hFFFFFF, 24'h0000FF, 24'hFF0000, 24'h00FFFF};
        write_reg(sgm_pkg::RegWidth, 3);
        write_reg(sgm_pkg::RegHeight, 3);
        foreach (pat[k]) send_pixel(pat[k]);
        // Max vertical step gives the full-scale magnitude 255
        foreach (pat[k]) send_pixel(k < 3 ? 24'hFFFFFF : (k < 6 ? 24'h808080 : 24'h000000));
    endtask

    task automatic test_clamped_sizes();
        write_reg(sgm_pkg::RegWidth, 0);      // clamps to 3
        write_reg(sgm_pkg::RegHeight, 2047);  // clamps to 1024
        write_reg(sgm_pkg::RegHeight, 1);     // clamps to 3
        send_frames(1);
    endtask

    task automatic test_random_frames();
        write_reg(sgm_pkg::RegWidth, 5);
        write_reg(sgm_pkg::RegHeight, 4);
        send_frames(2);
        write_reg(sgm_pkg::RegWidth, 7);
        write_reg(sgm_pkg::RegHeight, 6);
        send_frames(1);
    endtask

    // Stall the receiver long enough for the core to back up its input
    task automatic test_backpressure();
        write_reg(sgm_pkg::RegWidth, 4);
        write_reg(sgm_pkg::RegHeight, 4);
        hold_cycles = 300;
        send_frames(2);
    endtask

    task automatic test_no_gaps();
        send_gaps = 0;
        recv_gaps = 0;
        write_reg(sgm_pkg::RegWidth, 6);
        write_reg(sgm_pkg::RegHeight, 5);
        send_frames(1);
    endtask

    // Receiver readiness with random bursts and a long hold
    initial begin
        int n;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each result against the oldest prediction
    always @(posedge i_clk) begin
        t_grad act, exp_g;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act = {m_axis_tlast, m_axis_tdata[97:0]};
            if (grad_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", act);
            end else begin
                exp_g = grad_q.pop_front();
                if (act !== exp_g) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", exp_g, act);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            timed_out = 1;
        end
    end

    initial begin
        cfg_w = 640;
        cfg_h = 480;
        cur_row = 0;
        cur_col = 0;
        foreach (win[k]) win[k] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_clamped_sizes();
        test_random_frames();
        test_backpressure();
        test_no_gaps();
        drain();
        if (mismatches == 0 && grad_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        wait (timed_out);
        $display("Some tests failed");
        $finish;
    end

endmodule
